>>> src/ble_pkg.sv
// Package for the bounded line editor.
// Holds widths, byte codes, command and result codes and the command type.
// No dependencies.
package ble_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int CNT_W  = 6;
	localparam int KIND_W = 2;
	localparam int OP_W   = 2;

	localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;

	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
	localparam logic [OP_W-1:0] OP_BS    = 2'd1;
	localparam logic [OP_W-1:0] OP_ENTER = 2'd2;

	localparam logic [CNT_W-1:0] MAX_LEN_RESET = 6'd32;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} cmd_t;

endpackage

>>> src/ble_rx_if.sv
// Input channel of the bounded line editor: one raw keyboard byte per request.
// Depends on ble_pkg.
interface ble_rx_if;
	logic                       valid;
	logic                       ready;
	logic [ble_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/ble_res_if.sv
// Result channel of the bounded line editor: one echo, line character or end item per request.
// Depends on ble_pkg.
interface ble_res_if;
	logic                       valid;
	logic                       ready;
	logic [ble_pkg::KIND_W-1:0] out_kind;
	logic [ble_pkg::BYTE_W-1:0] out_byte;
	logic [ble_pkg::CNT_W-1:0]  line_length;
	logic                       last;

	modport source (output valid, output out_kind, output out_byte, output line_length,
		output last, input ready);
	modport sink (input valid, input out_kind, input out_byte, input line_length,
		input last, output ready);
endinterface

>>> src/bounded_line_editor.sv
// Bounded line editor top level: front end, two-entry command queue, back end.
// A byte that yields a command enters the queue at the edge that accepts it; with the back end
// free its echo or end result is registered at the next edge, while a non-empty line's first
// character is first read from the line store into a register. Echo results come one per cycle,
// and Enter reads the line store at one character per cycle, while the result channel is ready.
// Asynchronous active-low reset empties the line, the queue and the output and sets the
// length limit to 32; the line store itself is not cleared. Depends on ble_pkg and the interfaces.
module bounded_line_editor #(
	parameter int LINE_DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ble_pkg::CNT_W-1:0] cfg_wdata,
	ble_rx_if.sink                    rx,
	ble_res_if.source                 res
);
	import ble_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	ble_front #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.push_ready(push_ready)
	);

	ble_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.push_ready(push_ready),
		.pop_valid (q_valid),
		.pop_cmd   (q_cmd),
		.pop       (q_pop)
	);

	ble_back #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_cmd  (q_cmd),
		.q_pop  (q_pop),
		.res    (res)
	);
endmodule

>>> src/ble_front.sv
// Front end of the bounded line editor: accepts keyboard bytes, turns each byte it acts on into a
// command, and tracks the character count and the length limit. Depends on ble_pkg, ble_rx_if.
module ble_front #(
	parameter int LINE_DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ble_pkg::CNT_W-1:0] cfg_wdata,
	ble_rx_if.sink                    rx,
	output logic                      push_valid,
	output ble_pkg::cmd_t             push_cmd,
	input  logic                      push_ready
);
	import ble_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

	logic [CNT_W-1:0]  max_len_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] b;
	logic              accept;
	logic              is_enter;
	logic              is_bs;
	logic              is_print;
	logic              has_room;

	assign rx.ready = push_ready;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign is_enter = (b == CH_LF) || (b == CH_CR);
	assign is_bs    = (b == CH_BS) || (b == CH_DEL);
	assign is_print = b inside {[CH_SPACE:CH_TILDE]};
	assign has_room = (count_q < max_len_q) && (count_q < DEPTH_C);

	always_comb begin
		push_valid     = 1'b0;
		push_cmd.op    = OP_ENTER;
		push_cmd.data  = b[CHAR_W-1:0];
		push_cmd.count = count_q;
		if (accept) begin
			if (is_enter) begin
				push_valid = 1'b1;
			end else if (is_bs && (count_q != '0)) begin
				push_valid  = 1'b1;
				push_cmd.op = OP_BS;
			end else if (is_print && has_room) begin
				push_valid  = 1'b1;
				push_cmd.op = OP_PRINT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			count_q   <= '0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (accept) begin
				if (is_enter) begin
					count_q <= '0;
				end else if (is_bs && (count_q != '0)) begin
					count_q <= count_q - 1'b1;
				end else if (is_print && has_room) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end
endmodule

>>> src/ble_queue.sv
// Two-entry command queue between the front and back ends of the line editor.
// Depends on ble_pkg.
module ble_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  ble_pkg::cmd_t push_cmd,
	output logic          push_ready,
	output logic          pop_valid,
	output ble_pkg::cmd_t pop_cmd,
	input  logic          pop
);
	import ble_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end
endmodule

>>> src/ble_back.sv
// Back end of the line editor: holds the line store, carries out queued commands and
// drives the registered result channel. Depends on ble_pkg, ble_res_if.
module ble_back #(
	parameter int LINE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  ble_pkg::cmd_t q_cmd,
	output logic          q_pop,
	ble_res_if.source     res
);
	import ble_pkg::*;

	localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BS2  = 3'd1;
	localparam logic [2:0] ST_BS3  = 3'd2;
	localparam logic [2:0] ST_CHAR = 3'd3;
	localparam logic [2:0] ST_END  = 3'd4;

	logic [CHAR_W-1:0] mem_q [LINE_DEPTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_d;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  len_d;
	logic              adv;
	logic              load;
	logic [KIND_W-1:0] kind_d;
	logic [BYTE_W-1:0] byte_d;
	logic [CNT_W-1:0]  olen_d;
	logic              last_d;
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [CNT_W-1:0]  out_len_q;
	logic              out_last_q;

	assign adv = !out_valid_q || res.ready;

	always_comb begin
		q_pop   = 1'b0;
		load    = 1'b0;
		kind_d  = KIND_ECHO;
		byte_d  = CH_BS;
		olen_d  = '0;
		last_d  = 1'b0;
		state_d = state_q;
		idx_d   = idx_q;
		len_d   = len_q;
		case (state_q)
			ST_IDLE: begin
				if (adv && q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						OP_PRINT: begin
							load   = 1'b1;
							byte_d = {1'b0, q_cmd.data};
							last_d = 1'b1;
						end
						OP_BS: begin
							load    = 1'b1;
							state_d = ST_BS2;
						end
						OP_ENTER: begin
							if (q_cmd.count == '0) begin
								load   = 1'b1;
								kind_d = KIND_END;
								byte_d = CH_LF;
								last_d = 1'b1;
							end else begin
								state_d = ST_CHAR;
								idx_d   = '0;
								len_d   = q_cmd.count;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_BS2: begin
				if (adv) begin
					load    = 1'b1;
					byte_d  = CH_SPACE;
					state_d = ST_BS3;
				end
			end
			ST_BS3: begin
				if (adv) begin
					load    = 1'b1;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CHAR: begin
				if (adv) begin
					load   = 1'b1;
					kind_d = KIND_CHAR;
					byte_d = {1'b0, rd_data_q};
					idx_d  = idx_q + 1'b1;
					if (idx_d == len_q) begin
						state_d = ST_END;
					end
				end
			end
			ST_END: begin
				if (adv) begin
					load    = 1'b1;
					kind_d  = KIND_END;
					byte_d  = CH_LF;
					olen_d  = len_q;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_addr = '0;
		if ((state_d == ST_CHAR) && (idx_d < DEPTH_C)) begin
			rd_addr = idx_d[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.op == OP_PRINT)) begin
			mem_q[q_cmd.count[IDX_W-1:0]] <= q_cmd.data;
		end
		rd_data_q <= mem_q[rd_addr];
		idx_q     <= idx_d;
		len_q     <= len_d;
		if (load) begin
			out_kind_q <= kind_d;
			out_byte_q <= byte_d;
			out_len_q  <= olen_d;
			out_last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_kind    = out_kind_q;
	assign res.out_byte    = out_byte_q;
	assign res.line_length = out_len_q;
	assign res.last        = out_last_q;
endmodule
